FILE: rtl/sdc_pkg.sv
package sdc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_STICK_RADIUS = 3'd0;
    localparam logic [2:0] REG_STICK_DZ     = 3'd1;
    localparam logic [2:0] REG_SUB_RADIUS   = 3'd2;
    localparam logic [2:0] REG_SUB_DZ       = 3'd3;
    localparam logic [2:0] REG_TRIG_FLOOR   = 3'd4;
    localparam logic [2:0] REG_TRIG_CEIL    = 3'd5;

    // Reset values of the registers
    localparam logic [6:0] RST_STICK_RADIUS = 7'd56;
    localparam logic [6:0] RST_STICK_DZ     = 7'd15;
    localparam logic [6:0] RST_SUB_RADIUS   = 7'd44;
    localparam logic [6:0] RST_SUB_DZ       = 7'd15;
    localparam logic [7:0] RST_TRIG_FLOOR   = 8'd30;
    localparam logic [7:0] RST_TRIG_CEIL    = 8'd180;

    // Pipeline shape of one stick lane
    localparam int SQRT_STEPS = 8;
    localparam int DIV_STEPS  = 7;
    localparam int LANE_LAT   = 2 + SQRT_STEPS + DIV_STEPS;

    typedef struct packed {
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic signed [7:0] sub_x;
        logic signed [7:0] sub_y;
        logic [7:0]        trig_left;
        logic [7:0]        trig_right;
        logic              has_error;
    } t_in;

    typedef struct packed {
        logic signed [7:0] clamped_stick_x;
        logic signed [7:0] clamped_stick_y;
        logic signed [7:0] clamped_sub_x;
        logic signed [7:0] clamped_sub_y;
        logic [7:0]        clamped_trig_left;
        logic [7:0]        clamped_trig_right;
    } t_out;

    typedef struct packed {
        logic [6:0] stick_radius;
        logic [6:0] stick_dead_zone;
        logic [6:0] sub_radius;
        logic [6:0] sub_dead_zone;
        logic [7:0] trigger_floor;
        logic [7:0] trigger_ceiling;
    } t_cfg;

endpackage

FILE: rtl/sdc_pair.sv
module sdc_pair (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic signed [7:0] i_x,
    input  logic signed [7:0] i_y,
    input  logic [6:0]        i_radius,
    input  logic [6:0]        i_dz,
    output logic signed [7:0] o_x,
    output logic signed [7:0] o_y
);

    localparam int NS = sdc_pkg::LANE_LAT - 1;

    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [14:0]       px;
        logic [14:0]       py;
        logic              clamp;
    } t_carry;

    // stage A: dead zone removed
    logic signed [7:0] r_dx, r_dy;
    // per-stage carried data, stage 0 is the product stage
    t_carry     r_c    [0:NS-1];
    logic [15:0] r_rem [0:sdc_pkg::SQRT_STEPS];
    logic [7:0]  r_root[0:sdc_pkg::SQRT_STEPS];
    logic [14:0] r_qx_rem [1:sdc_pkg::DIV_STEPS];
    logic [14:0] r_qy_rem [1:sdc_pkg::DIV_STEPS];
    logic [6:0]  r_qx [1:sdc_pkg::DIV_STEPS];
    logic [6:0]  r_qy [1:sdc_pkg::DIV_STEPS];
    logic [7:0]  r_len[1:sdc_pkg::DIV_STEPS];

    function automatic logic signed [7:0] dead_zone(logic signed [7:0] a, logic [6:0] dz);
        logic signed [8:0] a9;
        logic signed [8:0] d9;
        logic signed [8:0] r9;
        a9 = {a[7], a};
        d9 = {2'b00, dz};
        if ((a9 > -d9) && (a9 < d9)) r9 = '0;
        else if (a9 > 0)             r9 = a9 - d9;
        else                         r9 = a9 + d9;
        return r9[7:0];
    endfunction

    function automatic logic [7:0] mag8(logic signed [7:0] a);
        return a[7] ? 8'(-{a[7], a}) : 8'(a);
    endfunction

    // remove dead zone
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= dead_zone(i_x, i_dz);
            r_dy <= dead_zone(i_y, i_dz);
        end
    end

    // squared length, scaled magnitudes and the clamp decision
    logic [7:0]  ax, ay;
    logic [15:0] n_mag;
    assign ax    = mag8(r_dx);
    assign ay    = mag8(r_dy);
    assign n_mag = 16'(ax * ax) + 16'(ay * ay);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0].x     <= r_dx;
            r_c[0].y     <= r_dy;
            r_c[0].px    <= 15'(ax * i_radius);
            r_c[0].py    <= 15'(ay * i_radius);
            r_c[0].clamp <= (16'(i_radius * i_radius) < n_mag);
            r_rem[0]     <= n_mag;
            r_root[0]    <= '0;
        end
    end

    // carry side data down the lane
    genvar k;
    generate
        for (k = 1; k < NS; k++) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) r_c[k] <= r_c[k-1];
            end
        end

        // floor square root, one result bit per stage
        for (k = 0; k < sdc_pkg::SQRT_STEPS; k++) begin : g_sqrt
            localparam int B = sdc_pkg::SQRT_STEPS - 1 - k;
            logic [16:0] t;
            assign t = (17'(r_root[k]) << (B + 1)) + (17'd1 << (2 * B));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (17'(r_rem[k]) >= t) begin
                        r_rem[k+1]  <= 16'(17'(r_rem[k]) - t);
                        r_root[k+1] <= r_root[k] | (8'd1 << B);
                    end else begin
                        r_rem[k+1]  <= r_rem[k];
                        r_root[k+1] <= r_root[k];
                    end
                end
            end
        end
    endgenerate

    // restoring divide by the length, both axes side by side
    generate
        for (k = 0; k < sdc_pkg::DIV_STEPS; k++) begin : g_div
            localparam int B = sdc_pkg::DIV_STEPS - 1 - k;
            logic [14:0] rx, ry;
            logic [6:0]  qxi, qyi;
            logic [7:0]  len;
            logic [14:0] d;
            if (k == 0) begin : g_head
                // take the scaled magnitudes and the root, never divide by zero
                assign rx  = r_c[sdc_pkg::SQRT_STEPS].px;
                assign ry  = r_c[sdc_pkg::SQRT_STEPS].py;
                assign qxi = '0;
                assign qyi = '0;
                assign len = (r_root[sdc_pkg::SQRT_STEPS] == '0) ? 8'd1
                                                                : r_root[sdc_pkg::SQRT_STEPS];
            end else begin : g_body
                assign rx  = r_qx_rem[k];
                assign ry  = r_qy_rem[k];
                assign qxi = r_qx[k];
                assign qyi = r_qy[k];
                assign len = r_len[k];
            end
            assign d = 15'(len) << B;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_len[k+1] <= len;
                    if (rx >= d) begin
                        r_qx_rem[k+1] <= rx - d;
                        r_qx[k+1]     <= qxi | (7'd1 << B);
                    end else begin
                        r_qx_rem[k+1] <= rx;
                        r_qx[k+1]     <= qxi;
                    end
                    if (ry >= d) begin
                        r_qy_rem[k+1] <= ry - d;
                        r_qy[k+1]     <= qyi | (7'd1 << B);
                    end else begin
                        r_qy_rem[k+1] <= ry;
                        r_qy[k+1]     <= qyi;
                    end
                end
            end
        end
    endgenerate

    // apply sign, or keep the dead-zoned pair when inside the circle
    t_carry fc;
    logic [6:0] qx, qy;
    assign fc = r_c[NS-1];
    assign qx = r_qx[sdc_pkg::DIV_STEPS];
    assign qy = r_qy[sdc_pkg::DIV_STEPS];
    assign o_x = !fc.clamp ? fc.x : (fc.x[7] ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
    assign o_y = !fc.clamp ? fc.y : (fc.y[7] ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));

endmodule

FILE: rtl/sdc_trig.sv
module sdc_trig (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_v,
    input  logic [7:0] i_floor,
    input  logic [7:0] i_ceil,
    output logic [7:0] o_v
);

    logic [7:0] r_d [0:sdc_pkg::LANE_LAT-1];
    logic [7:0] lim;

    assign lim = (i_ceil < i_v) ? i_ceil : i_v;

    // floor and ceiling, then delay to match the stick lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= (i_v <= i_floor) ? 8'd0 : 8'(lim - i_floor);
            for (int j = 1; j < sdc_pkg::LANE_LAT; j++) r_d[j] <= r_d[j-1];
        end
    end

    assign o_v = r_d[sdc_pkg::LANE_LAT-1];

endmodule

FILE: rtl/stick_deadzone_circle_clamp_top.sv
// An accepted item passes through the lane stages and then the output register to o_valid.
// Throughput: one item per cycle; all lanes are fully pipelined, the
// square root and the divide each retire one bit per stage.
// A stalled output freezes the whole pipeline and raises o_stall.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults.
module stick_deadzone_circle_clamp_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sdc_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sdc_pkg::t_out  o_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data
);

    localparam int LAT = sdc_pkg::LANE_LAT;

    sdc_pkg::t_cfg r_cfg;
    logic          r_vld [0:LAT-1];
    sdc_pkg::t_in  r_raw [0:LAT-1];
    logic          r_out_valid;
    sdc_pkg::t_out r_out;
    logic          en;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_radius    <= sdc_pkg::RST_STICK_RADIUS;
            r_cfg.stick_dead_zone <= sdc_pkg::RST_STICK_DZ;
            r_cfg.sub_radius      <= sdc_pkg::RST_SUB_RADIUS;
            r_cfg.sub_dead_zone   <= sdc_pkg::RST_SUB_DZ;
            r_cfg.trigger_floor   <= sdc_pkg::RST_TRIG_FLOOR;
            r_cfg.trigger_ceiling <= sdc_pkg::RST_TRIG_CEIL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdc_pkg::REG_STICK_RADIUS: r_cfg.stick_radius    <= i_cfg_data[6:0];
                sdc_pkg::REG_STICK_DZ:     r_cfg.stick_dead_zone <= i_cfg_data[6:0];
                sdc_pkg::REG_SUB_RADIUS:   r_cfg.sub_radius      <= i_cfg_data[6:0];
                sdc_pkg::REG_SUB_DZ:       r_cfg.sub_dead_zone   <= i_cfg_data[6:0];
                sdc_pkg::REG_TRIG_FLOOR:   r_cfg.trigger_floor   <= i_cfg_data;
                sdc_pkg::REG_TRIG_CEIL:    r_cfg.trigger_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and raw item for the error bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_raw[0] <= i_data;
            for (int j = 1; j < LAT; j++) r_raw[j] <= r_raw[j-1];
        end
    end

    // lanes
    logic signed [7:0] sx, sy, ux, uy;
    logic [7:0]        tl, tr;

    sdc_pair u_main (
        .i_clk(i_clk), .i_en(en), .i_x(i_data.stick_x), .i_y(i_data.stick_y),
        .i_radius(r_cfg.stick_radius), .i_dz(r_cfg.stick_dead_zone),
        .o_x(sx), .o_y(sy)
    );

    sdc_pair u_sub (
        .i_clk(i_clk), .i_en(en), .i_x(i_data.sub_x), .i_y(i_data.sub_y),
        .i_radius(r_cfg.sub_radius), .i_dz(r_cfg.sub_dead_zone),
        .o_x(ux), .o_y(uy)
    );

    sdc_trig u_tl (
        .i_clk(i_clk), .i_en(en), .i_v(i_data.trig_left),
        .i_floor(r_cfg.trigger_floor), .i_ceil(r_cfg.trigger_ceiling), .o_v(tl)
    );

    sdc_trig u_tr (
        .i_clk(i_clk), .i_en(en), .i_v(i_data.trig_right),
        .i_floor(r_cfg.trigger_floor), .i_ceil(r_cfg.trigger_ceiling), .o_v(tr)
    );

    // merge lanes, bypass items flagged in error
    sdc_pkg::t_in rw;
    assign rw = r_raw[LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (rw.has_error) begin
                r_out.clamped_stick_x    <= rw.stick_x;
                r_out.clamped_stick_y    <= rw.stick_y;
                r_out.clamped_sub_x      <= rw.sub_x;
                r_out.clamped_sub_y      <= rw.sub_y;
                r_out.clamped_trig_left  <= rw.trig_left;
                r_out.clamped_trig_right <= rw.trig_right;
            end else begin
                r_out.clamped_stick_x    <= sx;
                r_out.clamped_stick_y    <= sy;
                r_out.clamped_sub_x      <= ux;
                r_out.clamped_sub_y      <= uy;
                r_out.clamped_trig_left  <= tl;
                r_out.clamped_trig_right <= tr;
            end
        end
    end

    // stall only comes from a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised without a waiting result");

    // a result appears only from the last lane stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[LAT-1] && !r_out_valid) |=> !o_valid)
        else $error("result appeared from an empty pipeline");

endmodule
